// ===== rtl/deq_pkg.sv =====
// Shared types and fixed field widths for the double-ended queue.
// No dependencies; imported by the queue top level.
package deq_pkg;

    localparam int MODE_W  = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 7;

    typedef enum logic [MODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ_IDX   = 3'd4,
        OP_WRITE_IDX  = 3'd5
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Result of one operation while its store read is in flight.
    typedef struct packed {
        t_status            status;
        logic               rd;
        logic [OCC_W-1:0]   occupancy;
    } t_resp;

endpackage

// ===== rtl/deq_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/double_ended_queue.sv =====
// Top level of the bounded double-ended queue held in a ring store.
// Depends on deq_pkg and deq_ram.
//
//  Channel  Direction  Handshake                 Word fields
//  -------  ---------  ------------------------  ------------------------------
//  in       to block   i_in_valid / o_in_stall   i_mode, i_value, i_position
//  out      from block o_out_valid / i_out_stall o_status, o_read_value,
//                                                o_occupancy
//
// One word is taken per cycle when the result path is moving; each result
// leaves through the registered read of the ring store RAM followed by the
// output register.
// Reset (i_rst_n low at a clock edge) empties the queue; the store itself
// is not cleared, since only entries that were written are ever read.
// A stalled output holds its word; the input stalls only when a result is
// waiting behind a stalled output word.
module double_ended_queue #(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [deq_pkg::MODE_W-1:0]           i_mode,
    input  logic signed [deq_pkg::VALUE_W-1:0]   i_value,
    input  logic [deq_pkg::POS_W-1:0]            i_position,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [deq_pkg::STAT_W-1:0]           o_status,
    output logic signed [deq_pkg::VALUE_W-1:0]   o_read_value,
    output logic [deq_pkg::OCC_W-1:0]            o_occupancy
);

    import deq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [PTR_W:0]   DEPTH_S   = (PTR_W + 1)'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    // Queue state: front slot and element count.
    logic [PTR_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;

    // Stage holding a result while its store read completes.
    logic  r_pend;
    t_resp r_resp, n_resp;

    // Output register.
    logic                 r_out_valid;
    t_status              r_status;
    logic [OCC_W-1:0]     r_occ;
    logic [VALUE_W-1:0]   r_rdata;

    logic                  out_free;
    logic                  acc;
    logic                  full;
    logic                  empty;
    logic                  in_range;
    logic [CNT_W-1:0]      offset;
    logic [PTR_W:0]        slot_sum;
    logic [PTR_W-1:0]      slot;
    logic [PTR_W-1:0]      front_dec;
    logic [PTR_W-1:0]      front_inc;
    logic [PTR_W-1:0]      addr;
    logic                  mem_we;
    logic                  mem_re;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic [WORD_WIDTH-1:0] mem_rdata;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_pend && !out_free;
    assign acc        = i_in_valid && !o_in_stall;

    assign full     = (r_count == FULL_CNT);
    assign empty    = (r_count == '0);
    assign in_range = (CMP_W'(i_position) < CMP_W'(r_count));

    // Logical offset from the front, valid whenever the operation is allowed.
    always_comb begin
        case (t_op'(i_mode))
            OP_PUSH_BACK: offset = r_count;
            OP_POP_BACK:  offset = r_count - CNT_W'(1);
            OP_READ_IDX,
            OP_WRITE_IDX: offset = CNT_W'(i_position);
            default:      offset = '0;
        endcase
    end

    // Front plus offset stays below twice the depth, so one subtract wraps it.
    assign slot_sum  = (PTR_W + 1)'(r_front) + (PTR_W + 1)'(offset);
    assign slot      = (slot_sum >= DEPTH_S) ? PTR_W'(slot_sum - DEPTH_S)
                                             : PTR_W'(slot_sum);
    assign front_dec = (r_front == '0) ? LAST_SLOT : r_front - PTR_W'(1);
    assign front_inc = (r_front == LAST_SLOT) ? '0 : r_front + PTR_W'(1);

    assign mem_wdata = WORD_WIDTH'($unsigned(i_value));

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        addr    = slot;
        n_resp  = '{status: ST_OK, rd: 1'b0, occupancy: '0};
        case (t_op'(i_mode))
            OP_PUSH_BACK: begin
                if (full) begin
                    n_resp.status = ST_FULL;
                end else begin
                    mem_we  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_PUSH_FRONT: begin
                addr = front_dec;
                if (full) begin
                    n_resp.status = ST_FULL;
                end else begin
                    mem_we  = 1'b1;
                    n_front = front_dec;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    n_resp.status = ST_EMPTY;
                end else begin
                    mem_re    = 1'b1;
                    n_resp.rd = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                addr = r_front;
                if (empty) begin
                    n_resp.status = ST_EMPTY;
                end else begin
                    mem_re    = 1'b1;
                    n_resp.rd = 1'b1;
                    n_front   = front_inc;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            OP_READ_IDX: begin
                if (!in_range) begin
                    n_resp.status = ST_RANGE;
                end else begin
                    mem_re    = 1'b1;
                    n_resp.rd = 1'b1;
                end
            end
            OP_WRITE_IDX: begin
                if (!in_range) begin
                    n_resp.status = ST_RANGE;
                end else begin
                    mem_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
        n_resp.occupancy = OCC_W'(n_count);
    end

    deq_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (acc && mem_we),
        .i_waddr (addr),
        .i_wdata (mem_wdata),
        .i_re    (acc && mem_re),
        .i_raddr (addr),
        .o_rdata (mem_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_front <= n_front;
                r_count <= n_count;
            end
            if (acc) begin
                r_pend <= 1'b1;
            end else if (out_free) begin
                r_pend <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_pend;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_resp <= n_resp;
        end
        if (out_free && r_pend) begin
            r_status <= r_resp.status;
            r_occ    <= r_resp.occupancy;
            r_rdata  <= r_resp.rd ? VALUE_W'(mem_rdata) : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_occupancy  = r_occ;
    assign o_read_value = r_rdata;

    // The element count never passes the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("element count exceeds depth");

    // A pending result moves to the output whenever the output is free.
    a_pend_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && out_free |=> r_out_valid)
        else $error("pending result was not delivered");

    // An accepted pop on a non-empty queue lowers the count by one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !empty && (i_mode == OP_POP_BACK || i_mode == OP_POP_FRONT)
        |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("pop did not lower the count");

    // An empty status always reports an empty queue.
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_EMPTY |-> r_occ == '0)
        else $error("empty status with nonzero occupancy");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the double_ended_queue ring-buffer deque.
// Depends on deq_pkg and the RTL under rtl/; holds its own scoreboard class.
module testbench;
    import deq_pkg::*;

    localparam int DEPTH      = 64;
    localparam int HALF_CLK   = 6;
    localparam int RESET_CYC  = 3;
    localparam int RANDOM_CNT = 1500;
    localparam int BURST_LEN  = 100;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYC  = 8;
    localparam int IDLE_PCT   = 36;

    // Mode codes the block treats as no operation.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    // The receiver holds off completely over this window of its own cycles.
    localparam int HOLD_START = 1000;
    localparam int HOLD_LEN   = 220;
    // Windows with no random idling on each side.
    localparam int RX_STEADY_START = 2000;
    localparam int RX_STEADY_LEN   = 500;
    localparam int TX_STEADY_START = 800;
    localparam int TX_STEADY_LEN   = 300;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} t_mix;

    // One expected result word.
    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [VALUE_W-1:0] read_value;
        logic [OCC_W-1:0]   occupancy;
    } t_expected;

    // Scoreboard: mirrors the deque and keeps the results still owed by the block.
    class deque_scoreboard;
        logic [VALUE_W-1:0] slots[DEPTH];
        int                 front;
        int                 held;
        int                 errors;
        t_expected          owed_results[$];

        function new();
            front  = 0;
            held   = 0;
            errors = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        function int slot_of(int offset);
            return (front + offset) % DEPTH;
        endfunction

        // Applies one accepted operation to the mirror and queues its result.
        function void note_word(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                                logic [POS_W-1:0] position);
            t_expected exp_word;
            exp_word.status     = ST_OK;
            exp_word.read_value = '0;
            case (mode)
                OP_PUSH_BACK: begin
                    if (held >= DEPTH) begin
                        exp_word.status = ST_FULL;
                    end else begin
                        slots[slot_of(held)] = value;
                        held++;
                    end
                end
                OP_PUSH_FRONT: begin
                    if (held >= DEPTH) begin
                        exp_word.status = ST_FULL;
                    end else begin
                        front = (front + DEPTH - 1) % DEPTH;
                        slots[front] = value;
                        held++;
                    end
                end
                OP_POP_BACK: begin
                    if (held == 0) begin
                        exp_word.status = ST_EMPTY;
                    end else begin
                        exp_word.read_value = slots[slot_of(held - 1)];
                        held--;
                    end
                end
                OP_POP_FRONT: begin
                    if (held == 0) begin
                        exp_word.status = ST_EMPTY;
                    end else begin
                        exp_word.read_value = slots[front];
                        front = (front + 1) % DEPTH;
                        held--;
                    end
                end
                OP_READ_IDX: begin
                    if (int'(position) >= held) begin
                        exp_word.status = ST_RANGE;
                    end else begin
                        exp_word.read_value = slots[slot_of(position)];
                    end
                end
                OP_WRITE_IDX: begin
                    if (int'(position) >= held) begin
                        exp_word.status = ST_RANGE;
                    end else begin
                        slots[slot_of(position)] = value;
                    end
                end
                default: begin
                end
            endcase
            exp_word.occupancy = held[OCC_W-1:0];
            owed_results.insert(owed_results.size(), exp_word);
        endfunction

        task report(string what, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(logic [STAT_W-1:0] status, logic [VALUE_W-1:0] read_value,
                          logic [OCC_W-1:0] occupancy);
            t_expected exp_word;
            if (owed_results.size() == 0) begin
                report("result with nothing owed", {30'd0, status}, '0);
            end else begin
                exp_word = owed_results[0];
                owed_results.delete(0);
                if (status !== exp_word.status)
                    report("status", {30'd0, status}, {30'd0, exp_word.status});
                if (read_value !== exp_word.read_value)
                    report("read value", read_value, exp_word.read_value);
                if (occupancy !== exp_word.occupancy)
                    report("occupancy", {25'd0, occupancy}, {25'd0, exp_word.occupancy});
            end
        endtask

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [MODE_W-1:0]         i_mode;
    logic signed [VALUE_W-1:0] i_value;
    logic [POS_W-1:0]          i_position;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [STAT_W-1:0]         o_status;
    logic signed [VALUE_W-1:0] o_read_value;
    logic [OCC_W-1:0]          o_occupancy;

    deque_scoreboard sb = new();

    // The sender idles at random only while this is set.
    bit sender_idles = 1'b1;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (VALUE_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_occupancy  (o_occupancy)
    );

    always begin
        #HALF_CLK i_clk = 1'b1;
        #HALF_CLK i_clk = 1'b0;
    end

    // Offers one word from a falling edge and holds it until the block takes it.
    // The mirror is updated at the accepting edge, so the next pick sees the
    // count the block will see.
    task send_word(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                   logic [POS_W-1:0] position);
        while (sender_idles && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_value    <= value;
        i_position <= position;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(mode, value, position);
        @(negedge i_clk);
    endtask

    // Values lean on the corners of the signed range now and then.
    function logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 39))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Positions mostly fall inside the occupied range so that reads and
    // writes do real work; the rest may land anywhere.
    function logic [POS_W-1:0] pick_position();
        if (sb.held > 0 && $urandom_range(0, 99) < 85)
            return POS_W'($urandom_range(0, sb.held - 1));
        return POS_W'($urandom_range(0, DEPTH - 1));
    endfunction

    // Chooses an operation under the current mix; a few percent are the
    // spare no-operation codes.
    function logic [MODE_W-1:0] pick_mode(t_mix mix);
        int roll;
        int push_top;
        int pop_top;
        int read_top;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                push_top = 66; pop_top = 78; read_top = 89;
            end
            MIX_DRAIN: begin
                push_top = 21; pop_top = 71; read_top = 86;
            end
            default: begin
                push_top = 36; pop_top = 61; read_top = 81;
            end
        endcase
        if (roll < 4)
            return (roll[0]) ? MODE_SPARE_HI : MODE_SPARE_LO;
        if (roll < push_top)
            return (roll[0]) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        if (roll < pop_top)
            return (roll[0]) ? OP_POP_FRONT : OP_POP_BACK;
        if (roll < read_top)
            return OP_READ_IDX;
        return OP_WRITE_IDX;
    endfunction

    // Receiver: random stalls, one long hold-off that lets the block back up
    // and stall its input, and a stretch where it never stalls.
    initial begin : receiver
        int rx_cycle;
        bit stall_now;
        rx_cycle = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                stall_now = 1'b1;
            else if (rx_cycle >= RX_STEADY_START && rx_cycle < RX_STEADY_START + RX_STEADY_LEN)
                stall_now = 1'b0;
            else
                stall_now = ($urandom_range(0, 99) < IDLE_PCT);
            i_out_stall <= stall_now;
        end
    end

    // Every accepted result is checked against the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_read_value, o_occupancy);
    end

    // The run fails if neither channel moves a word for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        t_mix mix;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_mode     = OP_PUSH_BACK;
        i_value    = '0;
        i_position = '0;
        repeat (RESET_CYC) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: corner values, every operation, and the refusals on
        // an empty queue and on indexes past the count.
        send_word(OP_POP_FRONT,  32'h1234_5678, 6'd0);   // pop front when empty
        send_word(OP_POP_BACK,   32'h1234_5678, 6'd0);   // pop back when empty
        send_word(OP_READ_IDX,   32'h0,         6'd0);   // any index on empty queue
        send_word(OP_WRITE_IDX,  32'hDEAD_BEEF, 6'd0);
        send_word(OP_PUSH_BACK,  32'h7FFF_FFFF, 6'd63);
        send_word(OP_PUSH_FRONT, 32'h8000_0000, 6'd0);
        send_word(OP_PUSH_BACK,  32'h0000_0000, 6'd0);
        send_word(OP_PUSH_FRONT, 32'hFFFF_FFFF, 6'd0);   // front steps from slot 63 to slot 62
        send_word(OP_READ_IDX,   32'h0,         6'd0);
        send_word(OP_READ_IDX,   32'h0,         6'd3);
        send_word(OP_READ_IDX,   32'h0,         6'd4);   // index equal to count
        send_word(OP_READ_IDX,   32'h0,         6'd63);
        send_word(OP_WRITE_IDX,  32'hA5A5_5A5A, 6'd1);
        send_word(OP_WRITE_IDX,  32'h5A5A_A5A5, 6'd63);
        send_word(OP_READ_IDX,   32'h0,         6'd1);
        send_word(MODE_SPARE_LO, 32'hFFFF_FFFF, 6'd63);
        send_word(MODE_SPARE_HI, 32'hFFFF_FFFF, 6'd63);
        send_word(OP_POP_BACK,   32'h0,         6'd0);
        send_word(OP_POP_FRONT,  32'h0,         6'd0);
        send_word(OP_POP_BACK,   32'h0,         6'd0);
        send_word(OP_POP_FRONT,  32'h0,         6'd0);
        send_word(OP_POP_FRONT,  32'h0,         6'd0);

        // Random part in bursts; the first burst fills the queue so that a
        // push on a full queue is reached early, later bursts pick a mix.
        mix = MIX_FILL;
        for (int n = 0; n < RANDOM_CNT; n++) begin
            if (n > 0 && n % BURST_LEN == 0)
                mix = t_mix'($urandom_range(0, 2));
            sender_idles = !(n >= TX_STEADY_START && n < TX_STEADY_START + TX_STEADY_LEN);
            send_word(pick_mode(mix), pick_value(), pick_position());
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/double_ended_queue.sv
tb/sv/testbench.sv
